FILE: hw/rtl/hlcs_pkg.sv
`default_nettype none
package hlcs_pkg;

  localparam int LAYERS      = 4;
  localparam int STACK_DEPTH = 8;
  localparam int ADDR_BITS   = 32;

  localparam int SLOTS  = LAYERS * STACK_DEPTH;
  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int HW     = $clog2(STACK_DEPTH + 1);
  localparam int LI_W   = (LAYERS > 1) ? $clog2(LAYERS) : 1;

  localparam logic [3:0] KIND_PUSH      = 4'd0;
  localparam logic [3:0] KIND_POP       = 4'd1;
  localparam logic [3:0] KIND_SET_DONE  = 4'd2;
  localparam logic [3:0] KIND_SET_END   = 4'd3;
  localparam logic [3:0] KIND_QUERY     = 4'd4;
  localparam logic [3:0] KIND_DECREMENT = 4'd5;
  localparam logic [3:0] KIND_TRY_END   = 4'd6;
  localparam logic [3:0] KIND_ADVANCE   = 4'd7;
  localparam logic [3:0] KIND_DECODE    = 4'd8;
  localparam logic [3:0] KIND_END_JUMP  = 4'd9;
  localparam logic [3:0] KIND_READ      = 4'd10;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;

  typedef logic [ADDR_BITS-1:0] addr_t;
  typedef logic [HW-1:0]        height_t;
  typedef logic [SLOT_W-1:0]    slot_t;
  typedef logic [LI_W-1:0]      layer_idx_t;

  typedef struct packed {
    logic [15:0]      count;
    addr_t [2:0]      addr;
    addr_t [2:0]      stride;
    addr_t            loop_start;
    addr_t            end_addr;
    logic             done;
  } ctx_t;

  typedef struct packed {
    logic [3:0]       kind;
    logic [15:0]      count;
    logic [2:0][31:0] base;
    logic [2:0][31:0] stride;
    logic [31:0]      loop_start;
    logic [31:0]      address;
    logic             flag;
  } req_t;

  typedef struct packed {
    ctx_t             top_ctx;
    logic             wr_en;
    logic             answer;
    logic [1:0]       status;
    height_t          h_next;
  } res_t;

  function automatic addr_t zext_addr(logic [31:0] v);
    logic [63:0] w;
    w = {32'b0, v};
    return w[ADDR_BITS-1:0];
  endfunction

  function automatic addr_t sext_addr(logic [31:0] v);
    logic [63:0] w;
    w = {{32{v[31]}}, v};
    return w[ADDR_BITS-1:0];
  endfunction

  function automatic logic [31:0] low32(addr_t a);
    logic [63:0] w;
    w = 64'(a);
    return w[31:0];
  endfunction

  function automatic layer_idx_t layer_idx(logic [1:0] layer);
    logic [63:0] w;
    w = {62'b0, layer};
    return w[LI_W-1:0];
  endfunction

  function automatic slot_t slot_of(layer_idx_t li, height_t pos);
    logic [31:0] s;
    s = 32'(li) * 32'(STACK_DEPTH) + 32'(pos);
    return s[SLOT_W-1:0];
  endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/hlcs_op_unit.sv
`default_nettype none
module hlcs_op_unit (
  input  wire hlcs_pkg::req_t    req,
  input  wire hlcs_pkg::height_t h,
  input  wire hlcs_pkg::ctx_t    rd_ctx,
  output hlcs_pkg::res_t         res
);

  hlcs_pkg::addr_t       addr;
  hlcs_pkg::ctx_t        mod_ctx;
  hlcs_pkg::ctx_t        push_ctx;
  logic [15:0]           cnt_dec;
  logic                  h_zero;
  logic                  full;

  assign addr    = hlcs_pkg::zext_addr(req.address);
  assign cnt_dec = rd_ctx.count - 16'd1;
  assign h_zero  = (h == '0);
  assign full    = (h >= hlcs_pkg::HW'(hlcs_pkg::STACK_DEPTH));

  always_comb begin
    push_ctx.count      = req.count;
    for (int g = 0; g < 3; g++) begin
      push_ctx.addr[g]   = hlcs_pkg::zext_addr(req.base[g]);
      push_ctx.stride[g] = hlcs_pkg::sext_addr(req.stride[g]);
    end
    push_ctx.loop_start = hlcs_pkg::zext_addr(req.loop_start);
    push_ctx.end_addr   = '0;
    push_ctx.done       = 1'b0;
  end

  always_comb begin
    mod_ctx        = rd_ctx;
    res.top_ctx    = rd_ctx;
    res.wr_en      = 1'b0;
    res.answer     = 1'b0;
    res.status     = hlcs_pkg::STATUS_OK;
    res.h_next     = h;
    case (req.kind)
      hlcs_pkg::KIND_PUSH: begin
        // an out-of-range layer arrives here with height forced to full
        if (full) begin
          res.status = hlcs_pkg::STATUS_FULL;
        end else begin
          res.top_ctx = push_ctx;
          res.wr_en   = 1'b1;
          res.h_next  = h + hlcs_pkg::HW'(1);
        end
      end
      hlcs_pkg::KIND_POP: begin
        // the read already fetched the entry below the old top
        if (!h_zero) res.h_next = h - hlcs_pkg::HW'(1);
      end
      hlcs_pkg::KIND_QUERY: begin
        res.answer = h_zero ? 1'b1 : rd_ctx.done;
      end
      hlcs_pkg::KIND_DECODE: begin
        res.answer = h_zero || (rd_ctx.end_addr == '0) || (addr <= rd_ctx.end_addr);
      end
      hlcs_pkg::KIND_SET_DONE, hlcs_pkg::KIND_SET_END, hlcs_pkg::KIND_DECREMENT,
      hlcs_pkg::KIND_TRY_END, hlcs_pkg::KIND_ADVANCE, hlcs_pkg::KIND_END_JUMP: begin
        if (h_zero) begin
          res.status = hlcs_pkg::STATUS_EMPTY;
        end else begin
          case (req.kind)
            hlcs_pkg::KIND_SET_DONE: begin
              mod_ctx.done = req.flag;
              res.wr_en    = 1'b1;
            end
            hlcs_pkg::KIND_SET_END: begin
              mod_ctx.end_addr = addr;
              res.wr_en        = 1'b1;
            end
            hlcs_pkg::KIND_DECREMENT: begin
              mod_ctx.count = cnt_dec;
              res.wr_en     = 1'b1;
              res.answer    = (cnt_dec == 16'd0);
            end
            hlcs_pkg::KIND_TRY_END: begin
              if (rd_ctx.end_addr == '0 || rd_ctx.end_addr == addr) begin
                mod_ctx.end_addr = addr;
                res.wr_en        = 1'b1;
                res.answer       = 1'b1;
              end
            end
            hlcs_pkg::KIND_ADVANCE: begin
              for (int g = 0; g < 3; g++) begin
                mod_ctx.addr[g] = rd_ctx.addr[g] + rd_ctx.stride[g];
              end
              res.wr_en = 1'b1;
            end
            default: begin
              res.answer = rd_ctx.done && (addr > rd_ctx.end_addr);
            end
          endcase
          res.top_ctx = mod_ctx;
        end
      end
      default: begin
        // read and unused kinds change nothing
      end
    endcase
  end

endmodule
`default_nettype wire

FILE: hw/rtl/hardware_loop_context_stack_top.sv
`default_nettype none
// ch    dir  handshake           payload
// in_   in   in_valid/in_stall   kind layer count base_a-c stride_a-c loop_start address flag
// out_  out  out_valid/out_stall answer addr_a-c top_loop_start empty_res status
//
// an item is read, then executed: the accepting edge reads the context memory; the edge that
// fires modifies the entry, writes it back and loads the result register
// the context memory has a single write and a single read port; in_stall stays
// high while an item is in flight, so the next read always sees the write-back
// reset empties every stack at once; a context read from an empty stack is never shown
// a stalled result holds the finished item; one more item may be accepted meanwhile
module hardware_loop_context_stack_top (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_valid,
  output logic        in_stall,
  input  wire  [3:0]  in_kind,
  input  wire  [1:0]  in_layer,
  input  wire  [15:0] in_count,
  input  wire  [31:0] in_base_a,
  input  wire  [31:0] in_stride_a,
  input  wire  [31:0] in_base_b,
  input  wire  [31:0] in_stride_b,
  input  wire  [31:0] in_base_c,
  input  wire  [31:0] in_stride_c,
  input  wire  [31:0] in_loop_start,
  input  wire  [31:0] in_address,
  input  wire         in_flag,
  output logic        out_valid,
  input  wire         out_stall,
  output logic        out_answer,
  output logic [31:0] out_addr_a,
  output logic [31:0] out_addr_b,
  output logic [31:0] out_addr_c,
  output logic [31:0] out_top_loop_start,
  output logic        out_empty_res,
  output logic [1:0]  out_status
);

  hlcs_pkg::ctx_t        mem [hlcs_pkg::SLOTS];
  hlcs_pkg::ctx_t        rd_ctx_r;
  hlcs_pkg::height_t     heights_r [hlcs_pkg::LAYERS];
  hlcs_pkg::req_t        req_r;
  hlcs_pkg::height_t     h_r;
  hlcs_pkg::layer_idx_t  li_r;
  logic                  layer_ok_r;
  logic                  busy_r;
  logic                  out_valid_r;
  logic                  answer_r;
  logic [31:0]           addr_a_r;
  logic [31:0]           addr_b_r;
  logic [31:0]           addr_c_r;
  logic [31:0]           loop_start_r;
  logic                  empty_r;
  logic [1:0]            status_r;

  logic                  in_xfer;
  logic                  fire;
  logic                  layer_ok;
  hlcs_pkg::layer_idx_t  li;
  hlcs_pkg::height_t     h_in;
  hlcs_pkg::height_t     rd_pos;
  hlcs_pkg::slot_t       rd_slot;
  hlcs_pkg::slot_t       wr_slot;
  hlcs_pkg::req_t        req;
  hlcs_pkg::res_t        res;

  assign in_stall = busy_r;
  assign in_xfer  = in_valid && !in_stall;
  assign fire     = busy_r && (!out_valid_r || !out_stall);

  assign layer_ok = (32'(in_layer) < hlcs_pkg::LAYERS);
  assign li       = hlcs_pkg::layer_idx(in_layer);
  assign h_in     = layer_ok ? heights_r[li] : '0;

  // pop reads the entry that becomes the new top
  always_comb begin
    rd_pos = '0;
    if (in_kind == hlcs_pkg::KIND_POP) begin
      if (h_in > hlcs_pkg::HW'(1)) rd_pos = h_in - hlcs_pkg::HW'(1) - hlcs_pkg::HW'(1);
    end else if (h_in != '0) begin
      rd_pos = h_in - hlcs_pkg::HW'(1);
    end
  end
  assign rd_slot = hlcs_pkg::slot_of(li, rd_pos);

  always_comb begin
    req.kind       = in_kind;
    req.count      = in_count;
    req.base       = {in_base_c, in_base_b, in_base_a};
    req.stride     = {in_stride_c, in_stride_b, in_stride_a};
    req.loop_start = in_loop_start;
    req.address    = in_address;
    req.flag       = in_flag;
  end

  // out-of-range layer behaves as empty, and a push there looks full
  hlcs_pkg::height_t h_eff;
  assign h_eff = (!layer_ok_r && req_r.kind == hlcs_pkg::KIND_PUSH)
                 ? hlcs_pkg::HW'(hlcs_pkg::STACK_DEPTH) : h_r;

  hlcs_op_unit u_op (
    .req    (req_r),
    .h      (h_eff),
    .rd_ctx (rd_ctx_r),
    .res    (res)
  );

  assign wr_slot = (req_r.kind == hlcs_pkg::KIND_PUSH)
                   ? hlcs_pkg::slot_of(li_r, h_r)
                   : hlcs_pkg::slot_of(li_r, h_r - hlcs_pkg::HW'(1));

  always_ff @(posedge clk) begin
    if (fire && res.wr_en) mem[wr_slot] <= res.top_ctx;
  end

  always_ff @(posedge clk) begin
    if (in_xfer) rd_ctx_r <= mem[rd_slot];
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      req_r      <= req;
      h_r        <= h_in;
      li_r       <= li;
      layer_ok_r <= layer_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
      for (int l = 0; l < hlcs_pkg::LAYERS; l++) heights_r[l] <= '0;
    end else begin
      if (in_xfer) begin
        busy_r <= 1'b1;
      end else if (fire) begin
        busy_r <= 1'b0;
      end
      if (fire) begin
        out_valid_r <= 1'b1;
        if (layer_ok_r) heights_r[li_r] <= res.h_next;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      answer_r <= res.answer;
      status_r <= res.status;
      if (res.h_next != '0) begin
        addr_a_r     <= hlcs_pkg::low32(res.top_ctx.addr[0]);
        addr_b_r     <= hlcs_pkg::low32(res.top_ctx.addr[1]);
        addr_c_r     <= hlcs_pkg::low32(res.top_ctx.addr[2]);
        loop_start_r <= hlcs_pkg::low32(res.top_ctx.loop_start);
        empty_r      <= 1'b0;
      end else begin
        addr_a_r     <= '0;
        addr_b_r     <= '0;
        addr_c_r     <= '0;
        loop_start_r <= '0;
        empty_r      <= 1'b1;
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_answer         = answer_r;
  assign out_addr_a         = addr_a_r;
  assign out_addr_b         = addr_b_r;
  assign out_addr_c         = addr_c_r;
  assign out_top_loop_start = loop_start_r;
  assign out_empty_res      = empty_r;
  assign out_status         = status_r;

  a_fire_loads_result: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_valid_r)
    else $error("executed item left no result");

  a_fire_frees_slot: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> !busy_r)
    else $error("item still in flight after execution");

  a_height_bound: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> h_r <= hlcs_pkg::HW'(hlcs_pkg::STACK_DEPTH))
    else $error("stack height beyond depth");

  a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && res.status == hlcs_pkg::STATUS_EMPTY) |-> h_r == '0)
    else $error("empty-stack status on a stack holding contexts");

  a_write_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && res.wr_en) |-> (layer_ok_r && res.h_next != '0))
    else $error("memory write without a live context");

endmodule
`default_nettype wire
